[hw/rtl/binary_majority_filter_3x3_unit_assert.svh]
// Assertion macros for the majority filter. Each use gives a label, the
// clock, the reset and the expressions to check.
`ifndef BINARY_MAJORITY_FILTER_3X3_UNIT_ASSERT_SVH
`define BINARY_MAJORITY_FILTER_3X3_UNIT_ASSERT_SVH

`ifndef SYNTH

// expr holds at every edge outside reset
`define BMF3_ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed: always");

// cond implies expr in the same cycle
`define BMF3_ASSERT_IMPLIES(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error("assertion failed: implies");

// cond implies expr in the next cycle
`define BMF3_ASSERT_NEXT(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error("assertion failed: next");

`else

`define BMF3_ASSERT_ALWAYS(label, clk, rst, expr)
`define BMF3_ASSERT_IMPLIES(label, clk, rst, cond, expr)
`define BMF3_ASSERT_NEXT(label, clk, rst, cond, expr)

`endif

`endif

[hw/rtl/bmf3_pkg.sv]
`default_nettype none

package bmf3_pkg;

   // bus widths fixed by the row format
   localparam int ROW_BITS   = 64;
   localparam int WIDTH_BITS = 7;
   localparam int THR_BITS   = 4;

   // reset values of the configuration registers
   localparam logic [WIDTH_BITS-1:0] GRID_WIDTH_RESET     = 7'd64;
   localparam logic [THR_BITS-1:0]   WALL_THRESHOLD_RESET = 4'd4;

   // configuration register indexes
   typedef enum logic [0:0] {
      CSR_GRID_WIDTH     = 1'b0,
      CSR_WALL_THRESHOLD = 1'b1
   } csr_index_type;

endpackage

`default_nettype wire

[hw/rtl/binary_majority_filter_3x3_unit.sv]
// Channel  Dir  Ports                                 Carries
// req      in   req_tvalid/tready/tdata/tlast         one grid row, bottom-row flag
// rsp      out  rsp_tvalid/tready/tdata/tlast         one smoothed row, frame-done flag
// csr      in   csr_valid/ready/index/data            grid width, wall threshold
//
// A row waits in the input register, then its window counts feed the result
// register: rows that are not the last of a frame go through at one per cycle.
// The bottom row of a multi-row frame stays in the input register until it has
// released two results through the single result register; a single-row frame, one.
// A stall keeps a row that emits in the input register and holds req_tready low.
// Synchronous active-high reset; configuration is taken in any cycle.
`default_nettype none

`include "binary_majority_filter_3x3_unit_assert.svh"

module binary_majority_filter_3x3_unit #(
   parameter int MAX_WIDTH = 64
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // req
   input  wire logic                                req_tvalid,
   output      logic                                req_tready,
   input  wire logic [bmf3_pkg::ROW_BITS-1:0]       req_tdata,  // [63:0] row_cells
   input  wire logic                                req_tlast,  // final_row
   // rsp
   output      logic                                rsp_tvalid,
   input  wire logic                                rsp_tready,
   output      logic [bmf3_pkg::ROW_BITS-1:0]       rsp_tdata,  // [63:0] smoothed_cells
   output      logic                                rsp_tlast,  // frame_done
   // csr
   input  wire logic                                csr_valid,
   output      logic                                csr_ready,
   input  wire bmf3_pkg::csr_index_type             csr_index,
   input  wire logic [bmf3_pkg::WIDTH_BITS-1:0]     csr_data
);

   import bmf3_pkg::*;

   localparam logic [WIDTH_BITS-1:0] MaxW = WIDTH_BITS'(MAX_WIDTH);

   // number of set cells in a 3x3 window given as three 3-cell slices
   function automatic logic [3:0] win_count(input logic [2:0] a,
                                            input logic [2:0] m,
                                            input logic [2:0] b);
      logic [3:0] sum;
      sum = 4'(a[0]) + 4'(a[1]) + 4'(a[2])
          + 4'(m[0]) + 4'(m[1]) + 4'(m[2])
          + 4'(b[0]) + 4'(b[1]) + 4'(b[2]);
      return sum;
   endfunction

   // configuration
   logic [WIDTH_BITS-1:0] grid_width_ff, grid_width_in;
   logic [THR_BITS-1:0]   wall_threshold_ff, wall_threshold_in;

   // input register
   logic                 s1_valid_ff, s1_valid_in;
   logic [MAX_WIDTH-1:0] s1_row_ff, s1_row_in;
   logic                 s1_last_ff, s1_last_in;
   logic                 phase_ff, phase_in;   // high: own result of bottom row pending

   // frame state
   logic [MAX_WIDTH-1:0] row_above_ff, row_above_in;
   logic [MAX_WIDTH-1:0] row_held_ff, row_held_in;
   logic                 holding_ff, holding_in;

   // result register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [ROW_BITS-1:0]  rsp_data_ff, rsp_data_in;
   logic                 rsp_last_ff, rsp_last_in;

   // control
   logic out_free, emit, advance, consume;
   logic [WIDTH_BITS-1:0] w_eff;
   logic [MAX_WIDTH-1:0]  use_mask, win_a, win_m, win_b, smoothed;
   logic [MAX_WIDTH+1:0]  pad_a, pad_m, pad_b;
   logic                  win_last;

   // configuration writes are always taken
   assign csr_ready = 1'b1;

   always_comb begin
      grid_width_in     = grid_width_ff;
      wall_threshold_in = wall_threshold_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_GRID_WIDTH:     grid_width_in     = csr_data;
            CSR_WALL_THRESHOLD: wall_threshold_in = csr_data[THR_BITS-1:0];
            default:            grid_width_in     = grid_width_ff;
         endcase
      end
   end

   // clamp the width to 1..MAX_WIDTH
   always_comb begin
      if (grid_width_ff == '0) begin
         w_eff = WIDTH_BITS'(1);
      end else if (grid_width_ff > MaxW) begin
         w_eff = MaxW;
      end else begin
         w_eff = grid_width_ff;
      end
      for (int x = 0; x < MAX_WIDTH; x++) begin
         use_mask[x] = (WIDTH_BITS'(x) < w_eff);
      end
   end

   // handshake: a result is emitted unless a first non-final row is only stored
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign emit     = phase_ff || holding_ff || s1_last_ff;
   assign advance  = s1_valid_ff && (out_free || !emit);
   assign consume  = advance && !(!phase_ff && holding_ff && s1_last_ff);
   assign req_tready = !s1_valid_ff || consume;

   // pick the window rows
   always_comb begin
      win_a    = row_above_ff;
      win_m    = (!phase_ff && !holding_ff) ? s1_row_ff : row_held_ff;
      win_b    = (!phase_ff && holding_ff) ? s1_row_ff : '1;
      win_last = phase_ff || !holding_ff;
   end

   // smooth: cells past the width and beyond either edge count as set
   always_comb begin
      pad_a = {1'b1, win_a | ~use_mask, 1'b1};
      pad_m = {1'b1, win_m | ~use_mask, 1'b1};
      pad_b = {1'b1, win_b | ~use_mask, 1'b1};
      for (int x = 0; x < MAX_WIDTH; x++) begin
         smoothed[x] = use_mask[x]
            && (win_count(pad_a[x +: 3], pad_m[x +: 3], pad_b[x +: 3]) > wall_threshold_ff);
      end
   end

   // advance the input register and frame state
   always_comb begin
      s1_valid_in  = s1_valid_ff;
      s1_row_in    = s1_row_ff;
      s1_last_in   = s1_last_ff;
      phase_in     = phase_ff;
      row_above_in = row_above_ff;
      row_held_in  = row_held_ff;
      holding_in   = holding_ff;
      if (advance) begin
         if (phase_ff) begin
            row_above_in = '1;
            holding_in   = 1'b0;
            phase_in     = 1'b0;
         end else if (holding_ff) begin
            row_above_in = row_held_ff;
            row_held_in  = s1_row_ff;
            phase_in     = s1_last_ff;
         end else if (!s1_last_ff) begin
            row_held_in  = s1_row_ff;
            holding_in   = 1'b1;
         end else begin
            row_above_in = '1;
         end
      end
      if (consume) begin
         s1_valid_in = 1'b0;
      end
      if (req_tvalid && req_tready) begin
         s1_valid_in = 1'b1;
         s1_row_in   = req_tdata[MAX_WIDTH-1:0];
         s1_last_in  = req_tlast;
      end
   end

   // load or drain the result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      if (advance && emit) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = ROW_BITS'(smoothed);
         rsp_last_in  = win_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_width_ff     <= GRID_WIDTH_RESET;
         wall_threshold_ff <= WALL_THRESHOLD_RESET;
         s1_valid_ff       <= 1'b0;
         phase_ff          <= 1'b0;
         row_above_ff      <= '1;
         holding_ff        <= 1'b0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         grid_width_ff     <= grid_width_in;
         wall_threshold_ff <= wall_threshold_in;
         s1_valid_ff       <= s1_valid_in;
         phase_ff          <= phase_in;
         row_above_ff      <= row_above_in;
         holding_ff        <= holding_in;
         rsp_valid_ff      <= rsp_valid_in;
      end
   end

   // payload needs no reset
   always_ff @(posedge clock) begin
      s1_row_ff   <= s1_row_in;
      s1_last_ff  <= s1_last_in;
      row_held_ff <= row_held_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   // a pending bottom-row result needs its row and a held row
   `BMF3_ASSERT_IMPLIES(a_phase_ctx, clock, reset, phase_ff, s1_valid_ff && holding_ff)
   // at frame start the row above is all wall
   `BMF3_ASSERT_IMPLIES(a_top_wall, clock, reset, !holding_ff, &row_above_ff)
   // the bottom row's own result returns the block to frame start
   `BMF3_ASSERT_NEXT(a_frame_end, clock, reset, advance && phase_ff, !holding_ff && !phase_ff)
   // the input register is never overwritten while it still holds work
   `BMF3_ASSERT_IMPLIES(a_no_overrun, clock, reset, req_tready && s1_valid_ff, consume)

endmodule

`default_nettype wire

[tb/sv/binary_majority_filter_3x3_unit_tb.sv]
`default_nettype none

module binary_majority_filter_3x3_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import bmf3_pkg::*;

   localparam int NUM_ROWS       = 1850;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int MAX_GAP        = 13;
   localparam int MAX_WIDTH      = 64;
   localparam logic [ROW_BITS-1:0] ALL_WALL = '1;

   // one step of the directed sequence: a register write or one row
   typedef struct packed {
      logic                  is_csr;
      csr_index_type         idx;
      logic [WIDTH_BITS-1:0] val;
      logic [ROW_BITS-1:0]   row;
      logic                  last_row;
      logic                  typed;
      logic [ROW_BITS-1:0]   typed_cells;
   } dir_step_type;

   // one refined row as it should leave the block
   typedef struct packed {
      logic [ROW_BITS-1:0] cells;
      logic                done;
   } smoothed_row_type;

   function automatic dir_step_type row_step(logic [ROW_BITS-1:0] r, logic l);
      dir_step_type s;
      s = '0;
      s.row = r;
      s.last_row = l;
      return s;
   endfunction

   // single-row frame whose refined row is written down directly
   function automatic dir_step_type typed_step(logic [ROW_BITS-1:0] r,
                                                logic [ROW_BITS-1:0] e);
      dir_step_type s;
      s = '0;
      s.row = r;
      s.last_row = 1'b1;
      s.typed = 1'b1;
      s.typed_cells = e;
      return s;
   endfunction

   function automatic dir_step_type csr_step(csr_index_type i, logic [WIDTH_BITS-1:0] v);
      dir_step_type s;
      s = '0;
      s.is_csr = 1'b1;
      s.idx = i;
      s.val = v;
      return s;
   endfunction

   localparam int NUM_DIRECTED = 30;
   localparam dir_step_type DIRECTED_STEPS [NUM_DIRECTED] = '{
      // reset settings: solid and empty single rows both fill up
      typed_step(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF),
      typed_step(64'h0000_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFFF),
      // multi-row frame, two results on the bottom row
      row_step(64'hAAAA_AAAA_AAAA_AAAA, 1'b0),
      row_step(64'h5555_5555_5555_5555, 1'b0),
      row_step(64'h0000_0000_0000_0000, 1'b0),
      row_step(64'hFFFF_FFFF_FFFF_FFFF, 1'b0),
      row_step(64'h0123_4567_89AB_CDEF, 1'b1),
      // threshold of nine or more clears everything
      csr_step(CSR_WALL_THRESHOLD, 7'd9),
      typed_step(64'hDEAD_BEEF_CAFE_F00D, 64'h0),
      csr_step(CSR_WALL_THRESHOLD, 7'd15),
      typed_step(64'h0000_0000_0000_0000, 64'h0),
      // width zero acts as one; upper data bits of the threshold are dropped
      csr_step(CSR_GRID_WIDTH, 7'd0),
      csr_step(CSR_WALL_THRESHOLD, 7'h70),
      typed_step(64'h0000_0000_0000_0000, 64'h1),
      // width past the maximum clamps to 64
      csr_step(CSR_GRID_WIDTH, 7'd127),
      csr_step(CSR_WALL_THRESHOLD, 7'd8),
      typed_step(64'h0000_0000_0000_0000, 64'h0),
      typed_step(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF),
      // single-cell rows: bits past the width read as wall
      csr_step(CSR_GRID_WIDTH, 7'd1),
      typed_step(64'hFFFF_FFFF_FFFF_FFFF, 64'h1),
      typed_step(64'hFFFF_FFFF_FFFF_FFFE, 64'h0),
      // one short of full width, edge cells
      csr_step(CSR_GRID_WIDTH, 7'd63),
      csr_step(CSR_WALL_THRESHOLD, 7'd4),
      row_step(64'h8000_0000_0000_0001, 1'b0),
      row_step(64'h0000_0000_0000_0000, 1'b0),
      row_step(64'h0000_0000_0000_0000, 1'b0),
      row_step(64'hFFFF_FFFF_FFFF_FFFF, 1'b1),
      csr_step(CSR_GRID_WIDTH, 7'd64),
      row_step(64'h0000_0001_8000_0000, 1'b0),
      row_step(64'h0000_0000_0000_0000, 1'b1)
   };

   logic                  clock;
   logic                  reset = 1'b1;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [ROW_BITS-1:0]   req_tdata;
   logic                  req_tlast;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [ROW_BITS-1:0]   rsp_tdata;
   logic                  rsp_tlast;
   logic                  csr_valid;
   logic                  csr_ready;
   csr_index_type         csr_index;
   logic [WIDTH_BITS-1:0] csr_data;

   binary_majority_filter_3x3_unit #(
      .MAX_WIDTH(MAX_WIDTH)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tlast (req_tlast),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tlast (rsp_tlast),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   // filter state as the testbench sees it
   logic [WIDTH_BITS-1:0] grid_width_reg = GRID_WIDTH_RESET;
   logic [THR_BITS-1:0]   wall_thr_reg   = WALL_THRESHOLD_RESET;
   logic [ROW_BITS-1:0]   upper_row      = ALL_WALL;
   logic [ROW_BITS-1:0]   waiting_row    = '0;
   logic                  row_waiting    = 1'b0;

   smoothed_row_type expected_rows [$];
   int unsigned   mismatches   = 0;
   int unsigned   rows_sent    = 0;
   int unsigned   idle_cycles  = 0;
   bit            send_burst   = 1'b0;
   bit            rsp_burst    = 1'b0;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // window cell; anything outside the grid is wall
   function automatic logic wall_at(logic [ROW_BITS-1:0] r, int i, int w);
      return (i < 0 || i >= w) ? 1'b1 : r[i];
   endfunction

   // one refined row from the rows above, at and below it
   function automatic logic [ROW_BITS-1:0] smooth_cells(logic [ROW_BITS-1:0] up,
                                                        logic [ROW_BITS-1:0] mid,
                                                        logic [ROW_BITS-1:0] dn);
      int w;
      int walls;
      logic [ROW_BITS-1:0] res;
      w = int'(grid_width_reg);
      if (w < 1) w = 1;
      if (w > MAX_WIDTH) w = MAX_WIDTH;
      res = '0;
      for (int x = 0; x < w; x++) begin
         walls = 0;
         for (int d = -1; d <= 1; d++) begin
            walls += int'(wall_at(up, x + d, w)) + int'(wall_at(mid, x + d, w))
                   + int'(wall_at(dn, x + d, w));
         end
         res[x] = (walls > int'(wall_thr_reg));
      end
      return res;
   endfunction

   // advance the row window on an accepted row and queue what it releases
   task automatic predict_row(logic [ROW_BITS-1:0] r, logic l, logic typed,
                              logic [ROW_BITS-1:0] typed_cells);
      smoothed_row_type res;
      if (row_waiting) begin
         res.cells = smooth_cells(upper_row, waiting_row, r);
         res.done = 1'b0;
         expected_rows.insert(expected_rows.size(), res);
         upper_row = waiting_row;
      end
      waiting_row = r;
      row_waiting = 1'b1;
      if (l) begin
         res.cells = typed ? typed_cells : smooth_cells(upper_row, waiting_row, ALL_WALL);
         res.done = 1'b1;
         expected_rows.insert(expected_rows.size(), res);
         upper_row = ALL_WALL;
         row_waiting = 1'b0;
      end
   endtask

   // present one row after a random gap and hold it until taken
   task automatic send_row(logic [ROW_BITS-1:0] r, logic l, logic typed,
                           logic [ROW_BITS-1:0] typed_cells);
      int gap;
      gap = send_burst ? 0 : $urandom_range(0, MAX_GAP);
      if ($urandom_range(0, 49) == 0) send_burst = !send_burst;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= r;
      req_tlast  <= l;
      do @(posedge clock); while (req_tready !== 1'b1);
      predict_row(r, l, typed, typed_cells);
      rows_sent++;
   endtask

   // drop valid and hold off until every refined row is out
   task automatic drain_rows();
      req_tvalid <= 1'b0;
      while (expected_rows.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   task automatic write_csr(csr_index_type i, logic [WIDTH_BITS-1:0] v);
      csr_valid <= 1'b1;
      csr_index <= i;
      csr_data  <= v;
      do @(posedge clock); while (csr_ready !== 1'b1);
      if (i == CSR_GRID_WIDTH) grid_width_reg = v;
      else wall_thr_reg = v[THR_BITS-1:0];
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [ROW_BITS-1:0] draw_row();
      logic [ROW_BITS-1:0] a;
      logic [ROW_BITS-1:0] b;
      a = {$urandom, $urandom};
      b = {$urandom, $urandom};
      case ($urandom_range(0, 5))
         0: return a & b;
         1: return a | b;
         2: return a & b & {$urandom, $urandom};
         3: return a | b | {$urandom, $urandom};
         4: return ~(64'h1 << $urandom_range(0, 63));
         default: return a;
      endcase
   endfunction

   // new settings between frames, extremes often
   task automatic reconfigure();
      logic [WIDTH_BITS-1:0] w;
      logic [WIDTH_BITS-1:0] t;
      case ($urandom_range(0, 7))
         0: w = 7'd0;
         1: w = 7'd1;
         2: w = 7'd64;
         3: w = 7'd127;
         4: w = 7'd63;
         default: w = WIDTH_BITS'($urandom_range(0, 127));
      endcase
      t = WIDTH_BITS'($urandom_range(0, 127));
      if ($urandom_range(0, 1) == 0) t[THR_BITS-1:0] = THR_BITS'($urandom_range(3, 6));
      case ($urandom_range(0, 3))
         0: write_csr(CSR_GRID_WIDTH, w);
         1: write_csr(CSR_WALL_THRESHOLD, t);
         2: begin
            write_csr(CSR_GRID_WIDTH, w);
            write_csr(CSR_WALL_THRESHOLD, t);
         end
         default: begin
            write_csr(CSR_WALL_THRESHOLD, t);
            write_csr(CSR_GRID_WIDTH, w);
         end
      endcase
   endtask

   // stimulus
   initial begin
      int frame_len;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tlast  <= 1'b0;
      csr_valid  <= 1'b0;
      csr_index  <= CSR_GRID_WIDTH;
      csr_data   <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int s = 0; s < NUM_DIRECTED; s++) begin
         if (DIRECTED_STEPS[s].is_csr) begin
            drain_rows();
            write_csr(DIRECTED_STEPS[s].idx, DIRECTED_STEPS[s].val);
         end else begin
            send_row(DIRECTED_STEPS[s].row, DIRECTED_STEPS[s].last_row,
                     DIRECTED_STEPS[s].typed, DIRECTED_STEPS[s].typed_cells);
         end
      end

      // random frames, mostly short
      while (rows_sent < NUM_ROWS) begin
         if ($urandom_range(0, 7) == 0) begin
            drain_rows();
            reconfigure();
         end else if ($urandom_range(0, 9) == 0) begin
            drain_rows();
         end
         case ($urandom_range(0, 9))
            0, 1: frame_len = 1;
            9: frame_len = $urandom_range(10, 30);
            default: frame_len = $urandom_range(2, 8);
         endcase
         for (int i = 0; i < frame_len; i++) begin
            send_row(draw_row(), i == frame_len - 1, 1'b0, '0);
         end
      end

      drain_rows();
      if (mismatches == 0) begin
         $display("[binary_majority_filter_3x3_unit] OK");
      end else begin
         $display("[binary_majority_filter_3x3_unit] ERROR");
      end
      $finish;
   end

   // result side: random stalls, compare each transaction with the oldest expectation
   initial begin
      int stall;
      smoothed_row_type want;
      rsp_tready <= 1'b0;
      wait (reset == 1'b0);
      forever begin
         stall = rsp_burst ? 0 : $urandom_range(0, MAX_GAP);
         if ($urandom_range(0, 39) == 0) rsp_burst = !rsp_burst;
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (rsp_tvalid !== 1'b1);
         if (expected_rows.size() == 0) begin
            if (mismatches < 10)
               $display("unexpected result: cells %h done %b", rsp_tdata, rsp_tlast);
            mismatches++;
         end else begin
            want = expected_rows.pop_front();
            if (rsp_tdata !== want.cells || rsp_tlast !== want.done) begin
               if (mismatches < 10)
                  $display("result mismatch: cells %h done %b, expected cells %h done %b",
                           rsp_tdata, rsp_tlast, want.cells, want.done);
               mismatches++;
            end
         end
      end
   end

   // watchdog: count cycles without any transaction
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("[binary_majority_filter_3x3_unit] ERROR");
         $finish;
      end
   end

endmodule

`default_nettype wire
